// ===== src/assert_macros.svh =====
// Assertion macros for the soft-start limiter and PCM converter.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clock edge outside reset.
`define SSLPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that cond in one cycle implies nxt in the following cycle.
`define SSLPC_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// ===== src/sslpc_pkg.sv =====
// Shared types and constants for the soft-start limiter and PCM converter.
// No dependencies.
package sslpc_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned PcmW    = 32;
  localparam int unsigned RampW   = 16;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned FmtW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned QShift  = 24;

  localparam logic [CfgIdxW-1:0] REG_RAMP_LEN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FORMAT   = 2'd2;

  localparam logic [FmtW-1:0] FMT_PCM16 = 3'd0;
  localparam logic [FmtW-1:0] FMT_PCM24 = 3'd1;
  localparam logic [FmtW-1:0] FMT_PCM32 = 3'd2;
  localparam logic [FmtW-1:0] FMT_PASS  = 3'd3;

  localparam logic [RampW-1:0] RAMP_LEN_RST = 16'd7200;
  localparam logic [ChanW-1:0] CHANNELS_RST = 4'd2;
  localparam logic [FmtW-1:0]  FORMAT_RST   = FMT_PCM16;

  localparam logic [31:0] UNITY_Q24 = 32'h0100_0000;
  localparam logic [31:0] K_PCM16   = 32'd32767;
  localparam logic [31:0] K_PCM24   = 32'd8388607;
  localparam logic [31:0] K_PCM32   = 32'd2147483647;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_CONV
  } state_e;

endpackage

// ===== src/sslpc_if.sv =====
// Valid/ready stream interfaces for the input samples and the PCM results.
// Depends on sslpc_pkg for field widths.
interface sslpc_in_if
  import sslpc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_in;
  logic                      restart_ramp;

  modport source (output valid, output sample_in, output restart_ramp, input ready);
  modport sink   (input valid, input sample_in, input restart_ramp, output ready);
endinterface

interface sslpc_out_if
  import sslpc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [PcmW-1:0] pcm_out;
  logic                   ramp_active;

  modport source (output valid, output pcm_out, output ramp_active, input ready);
  modport sink   (input valid, input pcm_out, input ramp_active, output ready);
endinterface

// ===== src/sslpc_div.sv =====
// Serial restoring divider for the fade-in gain: count * 2^GAIN_FRACTION_BITS / len.
// One quotient bit per cycle; requires count < len. Depends on sslpc_pkg.
module sslpc_div
  import sslpc_pkg::*;
#(
  parameter int unsigned GAIN_FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [RampW-1:0]              count_i,
  input  logic [RampW-1:0]              len_i,
  output logic                          done_o,
  output logic [GAIN_FRACTION_BITS-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(GAIN_FRACTION_BITS + 1);

  logic [RampW-1:0]              rem_q, rem_d;
  logic [GAIN_FRACTION_BITS-1:0] quot_q, quot_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [RampW:0]                trial;
  logic                          fits;

  always_comb begin
    trial  = {rem_q, 1'b0};
    fits   = trial >= {1'b0, len_i};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = count_i;
      quot_d = '0;
      cnt_d  = CntW'(GAIN_FRACTION_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? RampW'(trial - {1'b0, len_i}) : RampW'(trial);
      quot_d = {quot_q[GAIN_FRACTION_BITS-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/soft_start_limit_pcm_convert_unit.sv =====
// Soft-start fade-in, hard limiter and PCM converter for interleaved Q8.24 audio.
// Depends on sslpc_pkg, sslpc_if, sslpc_div and assert_macros.svh.
//
// in_i carries one Q8.24 sample per transfer, with restart_ramp marking a frame
// start that restarts the fade-in. out_o returns one converted sample per input,
// in order, with ramp_active set when the sample was scaled by the fade-in gain.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 ramp length, 1 channel count, 2 output format); write only while idle.
// One item at a time: in_i.ready is high only while the unit is idle.
// An unscaled sample goes from the input to the conversion step; a scaled one
// first passes the divide and scale steps. The fade-in gain comes from a
// serial divider that yields one quotient bit per cycle; one shared multiplier
// then applies the gain in the scale step, the PCM factor in the conversion step.
// A finished result sits in an output register; the next input is taken while
// it waits. If out_o.ready stays low, the following item holds in the
// conversion step until the output register frees.
// Reset restores ramp length 7200, 2 channels, pcm16 output, an active ramp at
// frame count 0 and frame position 0, and empties the output register.
module soft_start_limit_pcm_convert_unit
  import sslpc_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS       = 8,
  parameter int unsigned GAIN_FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  sslpc_in_if.sink           in_i,
  sslpc_out_if.source        out_o
);

  localparam int unsigned PosW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  state_e state_q, state_d;

  logic [RampW-1:0] len_q;
  logic [ChanW-1:0] chan_q;
  logic [FmtW-1:0]  fmt_q;

  logic [RampW-1:0] count_q, count_d;
  logic             ramping_q, ramping_d;
  logic [PosW-1:0]  pos_q, pos_d;

  logic             neg_q, neg_d;
  logic [31:0]      mag_q, mag_d;
  logic             active_q, active_d;

  logic             out_valid_q, out_valid_d;
  logic [PcmW-1:0]  pcm_q, pcm_d;
  logic             act_out_q, act_out_d;

  logic             in_fire;
  logic             out_fire;
  logic             restart;
  logic [ChanW:0]   chans;
  logic [ChanW:0]   pos_eff;
  logic [RampW-1:0] count_eff;
  logic             active_c;
  logic [31:0]      raw_mag;
  logic             div_start;
  logic             div_done;
  logic [GAIN_FRACTION_BITS-1:0] div_quot;
  logic [31:0]      mul_b;
  logic [63:0]      product;
  logic [31:0]      y_mag;
  logic [31:0]      y_signed;
  logic             slot_free;

  function automatic logic [31:0] clamp_unity(logic [31:0] m);
    return (m > UNITY_Q24) ? UNITY_Q24 : m;
  endfunction

  sslpc_div #(
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .count_i(count_eff),
    .len_i  (len_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.pcm_out     = pcm_q;
  assign out_o.ramp_active = act_out_q;

  // Frame bookkeeping for the item at the input.
  always_comb begin
    restart = in_i.restart_ramp;
    if (chan_q == '0) begin
      chans = (ChanW+1)'(1);
    end else if ({1'b0, chan_q} > (ChanW+1)'(MAX_CHANNELS)) begin
      chans = (ChanW+1)'(MAX_CHANNELS);
    end else begin
      chans = {1'b0, chan_q};
    end
    pos_eff   = (ChanW+1)'(pos_q);
    if (restart || pos_eff >= chans) begin
      pos_eff = '0;
    end
    count_eff = restart ? '0 : count_q;
    active_c  = (restart || ramping_q) && (count_eff < len_q);
    raw_mag   = in_i.sample_in[31] ? 32'(~in_i.sample_in + 32'sd1) : 32'(in_i.sample_in);
  end

  // Shared multiplier: gain in the scale step, PCM factor in the conversion step.
  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_b = 32'(div_quot);
    end else begin
      case (fmt_q)
        FMT_PCM16: mul_b = K_PCM16;
        FMT_PCM24: mul_b = K_PCM24;
        default:   mul_b = K_PCM32;
      endcase
    end
    product  = 64'(mag_q) * 64'(mul_b);
    y_mag    = 32'(product[63:QShift]);
    y_signed = neg_q ? 32'(~y_mag + 32'd1) : y_mag;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ramping_d   = ramping_q;
    pos_d       = pos_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !out_fire;
    pcm_d       = pcm_q;
    act_out_d   = act_out_q;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          neg_d     = in_i.sample_in[31];
          active_d  = active_c;
          ramping_d = active_c;
          if ((pos_eff + (ChanW+1)'(1)) >= chans) begin
            pos_d   = '0;
            count_d = active_c ? count_eff + RampW'(1) : count_eff;
          end else begin
            pos_d   = PosW'(pos_eff + (ChanW+1)'(1));
            count_d = count_eff;
          end
          if (active_c) begin
            mag_d     = raw_mag;
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            mag_d   = clamp_unity(raw_mag);
            state_d = ST_CONV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        mag_d   = clamp_unity(32'(product >> GAIN_FRACTION_BITS));
        state_d = ST_CONV;
      end
      ST_CONV: begin
        if (slot_free) begin
          case (fmt_q)
            FMT_PCM16, FMT_PCM32: pcm_d = y_signed;
            FMT_PCM24:            pcm_d = {8'h00, y_signed[23:0]};
            FMT_PASS:             pcm_d = neg_q ? 32'(~mag_q + 32'd1) : mag_q;
            default:              pcm_d = '0;
          endcase
          act_out_d   = active_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= RAMP_LEN_RST;
      chan_q      <= CHANNELS_RST;
      fmt_q       <= FORMAT_RST;
      count_q     <= '0;
      ramping_q   <= 1'b1;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ramping_q   <= ramping_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RAMP_LEN: len_q  <= cfg_data_i;
          REG_CHANNELS: chan_q <= cfg_data_i[ChanW-1:0];
          REG_FORMAT:   fmt_q  <= cfg_data_i[FmtW-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    active_q  <= active_d;
    pcm_q     <= pcm_d;
    act_out_q <= act_out_d;
  end

`include "assert_macros.svh"

  `SSLPC_ASSERT_NEXT(a_ramp_stays_off, !ramping_q && !(in_fire && in_i.restart_ramp), !ramping_q, "ramp resumed without restart")
  `SSLPC_ASSERT_NEXT(a_active_goes_div, in_fire && active_c, state_q == ST_DIV, "scaled sample skipped the divider")
  `SSLPC_ASSERT_NEXT(a_conv_delivers, state_q == ST_CONV && !out_valid_q, state_q == ST_IDLE && out_valid_q, "conversion did not load the output register")
  `SSLPC_ASSERT(a_div_only_in_div, div_done |-> state_q == ST_DIV, "divider finished outside the divide step")

endmodule
